// ----- hdl/pci_pkg.sv -----
// Shared types, constants and helpers for the palette color index block.
// Used by pci_ctrl, pci_dpath and palette_color_index_top. No dependencies.
`default_nettype none

package pci_pkg;

  // Palette geometry
  localparam int MAX_COLORS = 256;
  localparam int PAL_DEPTH  = 256;
  localparam int ADDR_W     = 8;
  localparam int CNT_W      = 9;
  localparam int CAP_LOG2   = $clog2(MAX_COLORS);
  localparam int COLOR_W    = 32;
  localparam int BPI_W      = 4;
  localparam int DIST_W     = 11;

  localparam logic [BPI_W-1:0]  BPI_RESET  = 4'd8;
  localparam logic [CNT_W-1:0]  CAP_LIMIT  = CNT_W'(MAX_COLORS);
  localparam logic [DIST_W-1:0] NEAR_LIMIT = DIST_W'(4);

  // Item kinds
  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_SET    = 2'd1,
    MODE_CLEAR  = 2'd2
  } pci_mode_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SET_RD,
    ST_DONE
  } pci_state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;    // capture input item, reset search
    logic scan_rd;  // read next palette entry of the search
    logic set_rd;   // read the slot named by a set item
    logic commit;   // update state, load output register
  } pci_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_end; // all used entries issued
  } pci_stat_t;

  // Doubled sum of per-channel absolute differences
  function automatic logic [DIST_W-1:0] color_dist(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
    logic [7:0]        x;
    logic [7:0]        y;
    logic [DIST_W-1:0] sum;
    sum = '0;
    for (int ch = 0; ch < 4; ch++) begin
      x = a[ch*8 +: 8];
      y = b[ch*8 +: 8];
      sum = sum + DIST_W'((x > y) ? (x - y) : (y - x));
    end
    return DIST_W'({sum[DIST_W-2:0], 1'b0});
  endfunction

endpackage

`default_nettype wire

// ----- hdl/pci_ctrl.sv -----
// Controller state machine for the palette color index block.
// Depends on pci_pkg; drives pci_dpath through pci_cmd_t commands.
`default_nettype none

module pci_ctrl
  import pci_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] mode,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire pci_stat_t  stat,
  output pci_cmd_t        cmd
);

  pci_state_t state;
  pci_state_t state_next;
  logic       out_valid_next;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          if (mode == MODE_LOOKUP) begin
            state_next = ST_SCAN;
          end else if (mode == MODE_SET) begin
            state_next = ST_SET_RD;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        // last compare lands on the edge that leaves this state
        if (stat.scan_end) begin
          state_next = ST_DONE;
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      ST_SET_RD: begin
        cmd.set_rd = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register occupancy
  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pci_dpath.sv -----
// Datapath of the palette color index block: palette memory, search unit,
// palette state and output register. Depends on pci_pkg.
`default_nettype none

module pci_dpath
  import pci_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire pci_cmd_t           cmd,
  output pci_stat_t               stat,
  input  wire logic               cfg_wr_en,
  input  wire logic [BPI_W-1:0]   cfg_wr_data,
  input  wire logic [1:0]         mode,
  input  wire logic [COLOR_W-1:0] color_value,
  input  wire logic [ADDR_W-1:0]  entry_index,
  output logic [ADDR_W-1:0]       result_index,
  output logic                    exact_hit,
  output logic                    newly_added,
  output logic                    write_ignored,
  output logic                    palette_modified,
  output logic [CNT_W-1:0]        entry_count
);

  // Captured item
  logic [1:0]         mode_q;
  logic [COLOR_W-1:0] color_q;
  logic [ADDR_W-1:0]  idx_q;

  // Palette state
  logic [BPI_W-1:0]   bpi;
  logic [CNT_W-1:0]   used_count;
  logic [CNT_W-1:0]   used_count_next;
  logic               mod_flag;
  logic               mod_flag_next;
  logic [CNT_W-1:0]   cap;

  // Memory and valid bits
  logic [COLOR_W-1:0] mem [PAL_DEPTH];
  logic [PAL_DEPTH-1:0] entry_vld;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [COLOR_W-1:0] rd_data;
  logic               rd_vld;
  logic [COLOR_W-1:0] entry;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;

  // Search
  logic [CNT_W-1:0]   scan_i;
  logic               cmp_vld;
  logic [ADDR_W-1:0]  cmp_i;
  logic [DIST_W-1:0]  cur_dist;
  logic [ADDR_W-1:0]  best_i;
  logic [DIST_W-1:0]  best_d;

  // Result of the item
  logic [ADDR_W-1:0]  res_next;
  logic               hit_next;
  logic               added_next;
  logic               ignored_next;

  // Capacity: 2^bpi capped at MAX_COLORS
  assign cap = (bpi >= BPI_W'(CAP_LOG2)) ? CAP_LIMIT : (CNT_W'(1) << bpi);

  assign stat.scan_end = (scan_i >= used_count);

  // Capture item and walk the search counter
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_q  <= mode;
      color_q <= color_value;
      idx_q   <= entry_index;
      scan_i  <= '0;
    end else if (cmd.scan_rd) begin
      scan_i  <= scan_i + CNT_W'(1);
    end
    cmp_i <= scan_i[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= cmd.scan_rd;
    end
  end

  // Palette memory, one write and one registered read per cycle
  assign rd_en   = cmd.scan_rd | cmd.set_rd;
  assign rd_addr = cmd.scan_rd ? scan_i[ADDR_W-1:0] : idx_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= color_q;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_vld  <= entry_vld[rd_addr];
    end
  end

  // Entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
    end else if (wr_en) begin
      entry_vld[wr_addr] <= 1'b1;
    end
  end

  assign entry    = rd_vld ? rd_data : '0;
  assign cur_dist = color_dist(color_q, entry);

  // Running minimum, lowest index wins ties
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best_d <= '1;
      best_i <= '0;
    end else if (cmp_vld && (cur_dist < best_d)) begin
      best_d <= cur_dist;
      best_i <= cmp_i;
    end
  end

  // Outcome of the item, applied on commit
  always_comb begin
    used_count_next = used_count;
    mod_flag_next   = mod_flag;
    res_next        = '0;
    hit_next        = 1'b0;
    added_next      = 1'b0;
    ignored_next    = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = idx_q;
    case (mode_q)
      MODE_LOOKUP: begin
        if (best_d == '0) begin
          res_next = best_i;
          hit_next = 1'b1;
        end else if (best_d <= NEAR_LIMIT) begin
          res_next = best_i;
        end else if (used_count < cap) begin
          // append the color
          wr_en           = cmd.commit;
          wr_addr         = used_count[ADDR_W-1:0];
          res_next        = used_count[ADDR_W-1:0];
          used_count_next = used_count + CNT_W'(1);
          mod_flag_next   = 1'b1;
          added_next      = 1'b1;
        end else begin
          res_next = best_i;
        end
      end
      MODE_SET: begin
        res_next = idx_q;
        if ({1'b0, idx_q} < cap) begin
          wr_en = cmd.commit;
          if (used_count <= {1'b0, idx_q}) begin
            used_count_next = {1'b0, idx_q} + CNT_W'(1);
            mod_flag_next   = 1'b1;
          end else if (entry != color_q) begin
            mod_flag_next = 1'b1;
          end
        end else begin
          ignored_next = 1'b1;
        end
      end
      MODE_CLEAR: begin
        used_count_next = '0;
        mod_flag_next   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Palette state registers; config write restarts the palette
  always_ff @(posedge clk) begin
    if (rst) begin
      bpi        <= BPI_RESET;
      used_count <= '0;
      mod_flag   <= 1'b0;
    end else if (cfg_wr_en) begin
      bpi        <= cfg_wr_data;
      used_count <= '0;
      mod_flag   <= 1'b0;
    end else if (cmd.commit) begin
      used_count <= used_count_next;
      mod_flag   <= mod_flag_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result_index     <= res_next;
      exact_hit        <= hit_next;
      newly_added      <= added_next;
      write_ignored    <= ignored_next;
      palette_modified <= mod_flag_next;
      entry_count      <= used_count_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/palette_color_index_top.sv -----
// Top level of the palette color index block.
// Depends on pci_pkg, pci_ctrl and pci_dpath.
//
//   channel  handshake             payload
//   input    in_valid / in_stall   mode, color_value, entry_index
//   output   out_valid / out_stall result_index, exact_hit, newly_added,
//                                  write_ignored, palette_modified, entry_count
//   config   cfg_wr_en             cfg_wr_data (bits_per_index)
//
// A lookup over n used entries (the count before the item) issues one palette
// read per cycle through the single memory read port until all n are read.
// Set and clear items skip the search; one item is worked at a time.
// Synchronous reset clears the entry valid bits, so the palette reads as zero
// right away with no clearing pass.
// The output register holds a result under out_stall; the next item is taken
// while it waits and stops in its final cycle until the register frees up.
`default_nettype none

module palette_color_index_top
  import pci_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [BPI_W-1:0]   cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         mode,
  input  wire logic [COLOR_W-1:0] color_value,
  input  wire logic [ADDR_W-1:0]  entry_index,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [ADDR_W-1:0]       result_index,
  output logic                    exact_hit,
  output logic                    newly_added,
  output logic                    write_ignored,
  output logic                    palette_modified,
  output logic [CNT_W-1:0]        entry_count
);

  pci_cmd_t  cmd;
  pci_stat_t stat;

  // Sequencer
  pci_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Palette memory, search and state
  pci_dpath u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .mode             (mode),
    .color_value      (color_value),
    .entry_index      (entry_index),
    .result_index     (result_index),
    .exact_hit        (exact_hit),
    .newly_added      (newly_added),
    .write_ignored    (write_ignored),
    .palette_modified (palette_modified),
    .entry_count      (entry_count)
  );

endmodule

`default_nettype wire

// ----- sim/palette_color_index_tb.sv -----
// Self-checking bench for palette_color_index_top: directed and random items are
// checked against a palette predictor kept inside the bench.
// Depends on pci_pkg and the palette_color_index_top RTL.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pci_pkg::*;

  localparam int         CLK_PERIOD     = 8;
  localparam int         RESET_CYCLES   = 12;
  localparam int         WATCHDOG_LIMIT = 4000;  // longest lookup reads 256 entries
  localparam int         SETTLE_CYCLES  = 270;
  localparam int         MAX_REPORTS    = 10;
  localparam int         IDLE_PERCENT   = 30;
  localparam int         NEAR_DIST      = 4;
  localparam int         PHASE_ITEMS    = 81;
  localparam logic [1:0] MODE_UNUSED    = 2'd3;

  // One result transfer, in port order
  typedef struct packed {
    logic [ADDR_W-1:0] slot;
    logic              hit;
    logic              added;
    logic              ignored;
    logic              modified;
    logic [CNT_W-1:0]  count;
  } pal_answer_t;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               cfg_wr_en   = 1'b0;
  logic [BPI_W-1:0]   cfg_wr_data = BPI_RESET;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [1:0]         mode        = MODE_LOOKUP;
  logic [COLOR_W-1:0] color_value = '0;
  logic [ADDR_W-1:0]  entry_index = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [ADDR_W-1:0]  result_index;
  logic               exact_hit;
  logic               newly_added;
  logic               write_ignored;
  logic               palette_modified;
  logic [CNT_W-1:0]   entry_count;

  // Bench copy of the palette state
  logic [COLOR_W-1:0] shadow_pal [PAL_DEPTH];
  logic [CNT_W-1:0]   shadow_used;
  logic               shadow_mod;
  logic [BPI_W-1:0]   shadow_bpi;

  pal_answer_t        awaited_answers [$];
  int                 error_count  = 0;
  int                 quiet_cycles = 0;
  logic               calm         = 1'b0;  // no idling on either side

  palette_color_index_top u_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .mode             (mode),
    .color_value      (color_value),
    .entry_index      (entry_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .result_index     (result_index),
    .exact_hit        (exact_hit),
    .newly_added      (newly_added),
    .write_ignored    (write_ignored),
    .palette_modified (palette_modified),
    .entry_count      (entry_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Palette slots available for a given index width
  function automatic int palette_capacity(input logic [BPI_W-1:0] bpi);
    int cap;
    cap = (bpi >= 9) ? 512 : (1 << bpi);
    return (cap > MAX_COLORS) ? MAX_COLORS : cap;
  endfunction

  // Twice the sum of the per-channel absolute differences
  function automatic int color_distance(input logic [COLOR_W-1:0] a,
                                        input logic [COLOR_W-1:0] b);
    int sum;
    int x;
    int y;
    sum = 0;
    for (int ch = 0; ch < 4; ch++) begin
      x = a[ch*8 +: 8];
      y = b[ch*8 +: 8];
      sum += (x > y) ? (x - y) : (y - x);
    end
    return 2 * sum;
  endfunction

  // Applies one accepted item to the shadow palette, returns its result
  function automatic pal_answer_t resolve_item(input logic [1:0]         kind,
                                               input logic [COLOR_W-1:0] color,
                                               input logic [ADDR_W-1:0]  slot_req);
    pal_answer_t ans;
    int          cap;
    int          best;
    int          best_dist;
    int          d;
    bit          found;
    ans   = '0;
    cap   = palette_capacity(shadow_bpi);
    found = 1'b0;
    case (kind)
      MODE_LOOKUP: begin
        for (int i = 0; i < shadow_used; i++) begin
          if (!found && shadow_pal[i] == color) begin
            ans.slot = ADDR_W'(i);
            ans.hit  = 1'b1;
            found    = 1'b1;
          end
        end
        if (!found) begin
          best      = 0;
          best_dist = 1 << 30;
          // strict compare keeps the lowest index on ties
          for (int i = 0; i < shadow_used; i++) begin
            d = color_distance(color, shadow_pal[i]);
            if (d < best_dist) begin
              best_dist = d;
              best      = i;
            end
          end
          if (best_dist <= NEAR_DIST) begin
            ans.slot = ADDR_W'(best);
          end else if (shadow_used < cap) begin
            shadow_pal[shadow_used[ADDR_W-1:0]] = color;
            ans.slot    = shadow_used[ADDR_W-1:0];
            ans.added   = 1'b1;
            shadow_used = shadow_used + 1'b1;
            shadow_mod  = 1'b1;
          end else begin
            ans.slot = ADDR_W'(best);
          end
        end
      end
      MODE_SET: begin
        ans.slot = slot_req;
        if (slot_req < cap) begin
          if (shadow_used <= slot_req) begin
            shadow_used = CNT_W'(slot_req) + 1'b1;
            shadow_mod  = 1'b1;
          end else if (shadow_pal[slot_req] != color) begin
            shadow_mod = 1'b1;
          end
          shadow_pal[slot_req] = color;
        end else begin
          ans.ignored = 1'b1;
        end
      end
      MODE_CLEAR: begin
        shadow_used = '0;
        shadow_mod  = 1'b0;
      end
      default: ;  // unused code leaves the state alone
    endcase
    ans.modified = shadow_mod;
    ans.count    = shadow_used;
    return ans;
  endfunction

  // Lookup color: mostly stored colors, exact or nudged, else fully random
  function automatic logic [COLOR_W-1:0] pick_lookup_color();
    logic [COLOR_W-1:0] c;
    int                 roll;
    roll = $urandom_range(99);
    if (shadow_used == 0 || roll >= 60) begin
      return $urandom();
    end
    c = shadow_pal[$urandom_range(int'(shadow_used) - 1)];
    if (roll < 30) begin
      return c;
    end else if (roll < 45) begin
      return c ^ (32'h1 << (8 * $urandom_range(3)));  // distance 2
    end else if (roll < 52) begin
      return c ^ (32'h2 << (8 * $urandom_range(3)));  // distance 4, the edge
    end
    return c ^ (32'h3 << (8 * $urandom_range(3)));    // distance 2 or 6
  endfunction

  // Drives one item and waits for its transfer
  task automatic send_item(input logic [1:0]         kind,
                           input logic [COLOR_W-1:0] color,
                           input logic [ADDR_W-1:0]  slot_req);
    int gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PERCENT) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= kind;
    color_value <= color;
    entry_index <= slot_req;
    do @(posedge clk); while (in_stall);
    awaited_answers.push_back(resolve_item(kind, color, slot_req));
  endtask

  // Holds the sender off until every result is back
  task automatic wait_for_answers();
    in_valid <= 1'b0;
    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write, only with the block idle
  task automatic write_bits_per_index(input logic [BPI_W-1:0] width);
    wait_for_answers();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= width;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_bpi  = width;
    shadow_used = '0;
    shadow_mod  = 1'b0;
  endtask

  // Empty palette after reset: add, exact hit, near hits, distance edge
  task automatic test_lookup_basics();
    send_item(MODE_LOOKUP, 32'h0000_0000, 8'h00);
    send_item(MODE_LOOKUP, 32'h0000_0000, 8'hFF);
    send_item(MODE_LOOKUP, 32'hFFFF_FFFF, 8'h00);
    send_item(MODE_LOOKUP, 32'h0000_0001, 8'h00);
    send_item(MODE_LOOKUP, 32'h0101_0000, 8'h00);
    send_item(MODE_LOOKUP, 32'h0000_0003, 8'h00);
    send_item(MODE_LOOKUP, 32'hFF00_0000, 8'h00);
  endtask

  // Set past the count, rewrite same and new color, clear keeps the colors, unused code
  task automatic test_set_and_clear();
    send_item(MODE_SET, 32'hA5A5_A5A5, 8'hFF);
    send_item(MODE_SET, 32'hFFFF_FFFF, 8'h01);
    send_item(MODE_SET, 32'h1234_5678, 8'h01);
    send_item(MODE_LOOKUP, 32'hA5A5_A5A5, 8'h00);
    send_item(MODE_CLEAR, 32'hFFFF_FFFF, 8'hFF);
    send_item(MODE_SET, 32'h5A5A_5A5A, 8'h06);
    send_item(MODE_LOOKUP, 32'h1234_5678, 8'h00);
    send_item(MODE_UNUSED, 32'hFFFF_FFFF, 8'hFF);
  endtask

  // Two slots: full palette picks the closest, ties go low, sets overflow
  task automatic test_small_capacity();
    write_bits_per_index(4'd1);
    send_item(MODE_LOOKUP, 32'h0000_0000, 8'h00);
    send_item(MODE_LOOKUP, 32'hFFFF_FFFF, 8'h00);
    send_item(MODE_LOOKUP, 32'hFF00_0000, 8'h00);
    send_item(MODE_LOOKUP, 32'hFFFF_0000, 8'h00);
    send_item(MODE_SET, 32'h0F0F_0F0F, 8'h02);
    send_item(MODE_SET, 32'h0F0F_0F0F, 8'hFF);
  endtask

  // Width zero gives one slot, widths above eight saturate
  task automatic test_width_extremes();
    write_bits_per_index(4'd0);
    send_item(MODE_LOOKUP, 32'h1122_3344, 8'h00);
    send_item(MODE_LOOKUP, 32'h5566_7788, 8'h00);
    send_item(MODE_SET, 32'h5566_7788, 8'h01);
    write_bits_per_index(4'd15);
    send_item(MODE_SET, 32'hFFFF_FFFF, 8'hFF);
    send_item(MODE_LOOKUP, 32'h00FF_00FF, 8'h00);
  endtask

  // Phases over several widths; one phase runs with no idling at all
  task automatic test_random_traffic();
    logic [BPI_W-1:0] widths [8] = '{4'd3, 4'd8, 4'd0, 4'd15, 4'd2, 4'd9, 4'd1, 4'd5};
    int               roll;
    int               cap;
    for (int ph = 0; ph < 8; ph++) begin
      write_bits_per_index(widths[ph]);
      calm = (ph == 3);
      cap  = palette_capacity(widths[ph]);
      repeat (PHASE_ITEMS) begin
        roll = $urandom_range(99);
        if (roll < 65) begin
          send_item(MODE_LOOKUP, pick_lookup_color(), ADDR_W'($urandom()));
        end else if (roll < 90) begin
          send_item(MODE_SET, $urandom(),
                    ADDR_W'($urandom_range(1) ? $urandom_range(cap - 1)
                                              : $urandom_range(255)));
        end else if (roll < 95) begin
          send_item(MODE_CLEAR, $urandom(), ADDR_W'($urandom()));
        end else begin
          send_item(MODE_UNUSED, $urandom(), ADDR_W'($urandom()));
        end
        if ($urandom_range(49) == 0) begin
          wait_for_answers();
        end
      end
    end
    calm = 1'b0;
  endtask

  // Receiver stalls at random
  always @(posedge clk) begin
    out_stall <= !rst && !calm && ($urandom_range(99) < IDLE_PERCENT);
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    pal_answer_t want;
    pal_answer_t got;
    if (!rst && out_valid && !out_stall) begin
      got = {result_index, exact_hit, newly_added, write_ignored,
             palette_modified, entry_count};
      if (awaited_answers.size() == 0) begin
        if (error_count < MAX_REPORTS) begin
          $display("%0t ns: result with none expected: slot %0d count %0d",
                   $time, got.slot, got.count);
        end
        error_count++;
      end else begin
        want = awaited_answers.pop_front();
        if (got !== want) begin
          if (error_count < MAX_REPORTS) begin
            $display("%0t ns: mismatch (exp/act) slot %0d/%0d hit %0b/%0b add %0b/%0b",
                     $time, want.slot, got.slot, want.hit, got.hit,
                     want.added, got.added);
            $display("  ignored %0b/%0b modified %0b/%0b count %0d/%0d",
                     want.ignored, got.ignored, want.modified, got.modified,
                     want.count, got.count);
          end
          error_count++;
        end
      end
    end
  end

  // Cycles since the last transfer or register write
  always @(posedge clk) begin
    if (rst || cfg_wr_en || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    for (int i = 0; i < PAL_DEPTH; i++) shadow_pal[i] = '0;
    shadow_used = '0;
    shadow_mod  = 1'b0;
    shadow_bpi  = BPI_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_lookup_basics();
    test_set_and_clear();
    test_small_capacity();
    test_width_extremes();
    test_random_traffic();

    wait_for_answers();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
hdl/pci_pkg.sv
hdl/pci_ctrl.sv
hdl/pci_dpath.sv
hdl/palette_color_index_top.sv
sim/palette_color_index_tb.sv
